/* hdl/lab_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lab_pkg: shared types and constants for the lagged additive byte cipher
// Register map codes, configuration port widths and fixed key layout.
// ----------------------------------------------------------------------------
package lab_pkg;

  localparam int DATA_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 5;
  localparam int KEY_VEC_W  = 128;   // two 64-bit key registers
  localparam int KEY_SLOTS  = 16;    // key bytes held in the registers

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

  typedef logic [DATA_W-1:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_DECRYPT = 8'd0,
    CFG_KEY_LENGTH   = 8'd1,
    CFG_KEY_LOW      = 8'd2,
    CFG_KEY_HIGH     = 8'd3
  } cfg_reg_t;

endpackage : lab_pkg
`default_nettype wire

/* hdl/lab_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lab_if: valid/ready channels of the lagged additive byte cipher
// Input byte channel, result byte channel and configuration write channel.
// ----------------------------------------------------------------------------
interface lab_in_if;
  import lab_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_in;
  logic  last_in;

  modport source  (output valid, output data_in, output last_in, input ready);
  modport sink    (input valid, input data_in, input last_in, output ready);
  modport monitor (input valid, input data_in, input last_in, input ready);
endinterface : lab_in_if

interface lab_out_if;
  import lab_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_out;
  logic  last_out;

  modport source  (output valid, output data_out, output last_out, input ready);
  modport sink    (input valid, input data_out, input last_out, output ready);
  modport monitor (input valid, input data_out, input last_out, input ready);
endinterface : lab_out_if

interface lab_cfg_if;
  import lab_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source  (output valid, output index, output wdata, input ready);
  modport sink    (input valid, input index, input wdata, output ready);
  modport monitor (input valid, input index, input wdata, input ready);
endinterface : lab_cfg_if
`default_nettype wire

/* hdl/lagged_additive_byte_cipher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lagged_additive_byte_cipher: autokey additive byte cipher, ciphertext feedback
// Adds (encrypt) or subtracts (decrypt) a key byte, then the ciphertext byte
// K positions back, modulo 256. Position clears after a beat flagged last.
// ----------------------------------------------------------------------------
// One byte per clock, sustained while the result side is not stalled. A byte is
// transformed in the cycle it is accepted and appears on the result register
// the cycle after. The feedback path is a ciphertext shift line of KEY_BYTES
// taps read at the tap chosen by key_length; it is updated in the same cycle
// the byte is accepted, so even a lag of one needs no stall. The input side is
// ready whenever the result register is empty or being taken. Configuration
// writes are accepted in every cycle out of reset and must only be made while
// no message is in flight.
module lagged_additive_byte_cipher
  import lab_pkg::*;
#(
  parameter int KEY_BYTES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lab_cfg_if.sink    cfg_bus,
  lab_in_if.sink     in_bus,
  lab_out_if.source  out_bus
);

  localparam int PW = $clog2(KEY_BYTES + 1);
  localparam int CW = (PW > KEY_LEN_W) ? PW : KEY_LEN_W;
  localparam int TW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [PW-1:0] KB_P = PW'(KEY_BYTES);

  // configuration registers
  logic                  mode_r;
  logic [KEY_LEN_W-1:0]  key_length_r;
  logic [CFG_DATA_W-1:0] key_low_r;
  logic [CFG_DATA_W-1:0] key_high_r;

  // message state
  logic [PW-1:0]         pos_r, pos_nxt;
  byte_t                 hist_r [KEY_BYTES];

  // result register
  logic                  out_valid_r, out_valid_nxt;
  byte_t                 out_data_r;
  logic                  out_last_r;

  logic                  in_fire;
  logic [CW-1:0]         kl_ext;
  logic [PW-1:0]         lag;
  logic [PW-1:0]         lag_m1;
  logic [TW-1:0]         tap;
  logic [CW-1:0]         pos_ext;
  logic [KEY_VEC_W-1:0]  key_vec;
  logic [3:0]            key_idx;
  byte_t                 key_sel;
  byte_t                 addend;
  byte_t                 sum;
  byte_t                 diff;
  byte_t                 dout;
  byte_t                 cipher;

  assign cfg_bus.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      key_length_r <= KEY_LEN_RESET;
      key_low_r    <= '0;
      key_high_r   <= '0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_MODE_DECRYPT: mode_r       <= cfg_bus.wdata[0];
        CFG_KEY_LENGTH:   key_length_r <= cfg_bus.wdata[KEY_LEN_W-1:0];
        CFG_KEY_LOW:      key_low_r    <= cfg_bus.wdata;
        CFG_KEY_HIGH:     key_high_r   <= cfg_bus.wdata;
        default: ;
      endcase
    end
  end

  assign in_bus.ready = rst_n && (!out_valid_r || out_bus.ready);
  assign in_fire      = in_bus.valid && in_bus.ready;

  // effective lag: zero acts as one, anything past the line length saturates
  always_comb begin
    kl_ext = CW'(key_length_r);
    if (kl_ext == '0) begin
      lag = PW'(1);
    end else if (kl_ext > CW'(KEY_BYTES)) begin
      lag = KB_P;
    end else begin
      lag = kl_ext[PW-1:0];
    end
  end

  assign lag_m1 = lag - PW'(1);
  assign tap    = lag_m1[TW-1:0];

  // key bytes past the two key registers read as zero
  assign pos_ext = CW'(pos_r);
  assign key_vec = {key_high_r, key_low_r};
  assign key_idx = pos_ext[3:0];
  assign key_sel = (pos_ext < CW'(KEY_SLOTS)) ? key_vec[{key_idx, 3'b000} +: DATA_W] : '0;

  assign addend = (pos_r < lag) ? key_sel : hist_r[tap];
  assign sum    = in_bus.data_in + addend;
  assign diff   = in_bus.data_in - addend;
  assign dout   = mode_r ? diff : sum;
  assign cipher = mode_r ? in_bus.data_in : sum;

  always_comb begin
    pos_nxt = pos_r;
    if (in_fire) begin
      if (in_bus.last_in) begin
        pos_nxt = '0;
      end else if (pos_r != KB_P) begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ciphertext delay line, tap i holds the byte i+1 beats back
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hist_r[0] <= cipher;
      for (int i = 1; i < KEY_BYTES; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= dout;
      out_last_r <= in_bus.last_in;
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.data_out = out_data_r;
  assign out_bus.last_out = out_last_r;

endmodule : lagged_additive_byte_cipher
`default_nettype wire

/* hdl/lab_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lab_checker: port-level checks for the lagged additive byte cipher
// Watches the channels over time and flags broken beat ordering.
// ----------------------------------------------------------------------------
module lab_checker
  import lab_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  cfg_ready,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  in_last,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire byte_t out_data,
  input wire logic  out_last
);

  // nothing left on the result side after reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every input beat shows up as a result the next cycle, last flag intact
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=>
      (out_valid && (out_last == $past(in_last))))
    else $error("input beat not presented as result");

  // a taken result with no new input leaves the output empty
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !(in_valid && in_ready)) |=>
      !out_valid)
    else $error("result repeated or invented");

  // empty result register must not hold back the input or configuration once out of reset
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !out_valid) |-> (in_ready && cfg_ready))
    else $error("input stalled with empty output");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_data) && $stable(out_last)))
    else $error("stalled result changed");

endmodule : lab_checker

bind lagged_additive_byte_cipher lab_checker u_lab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_ready (cfg_bus.ready),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_last   (in_bus.last_in),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_data  (out_bus.data_out),
  .out_last  (out_bus.last_out)
);
`default_nettype wire

/* sim/tb_lagged_additive_byte_cipher.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lagged_additive_byte_cipher: self-checking bench for the byte cipher
// Streams messages through the block under random source and sink idling.
// Every result beat is checked against a cycle-free model of the keyed and
// ciphertext-fed add/subtract, under many key, lag and mode settings.
// ----------------------------------------------------------------------------
module tb_lagged_additive_byte_cipher;
  import lab_pkg::*;

  localparam int          KEY_BYTES     = 16;
  localparam int unsigned RANDOM_TARGET = 650;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 3;
  localparam int unsigned WATCHDOG_NS   = 5_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 8'd4;

  typedef struct packed {
    byte_t data;
    logic  last;
  } out_beat_t;

  logic clk;
  logic rst_n;

  lab_cfg_if cfg_ch ();
  lab_in_if  in_ch ();
  lab_out_if out_ch ();

  lagged_additive_byte_cipher #(
    .KEY_BYTES (KEY_BYTES)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_ch),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  // shadow of the register file and the message state
  logic                  sh_decrypt;
  logic [KEY_LEN_W-1:0]  sh_key_len;
  logic [KEY_VEC_W-1:0]  sh_key;
  int unsigned           msg_pos;
  int unsigned           fb_ptr;
  byte_t                 fb_line [KEY_BYTES];

  out_beat_t   expected_out [$];
  int unsigned error_count     = 0;
  int unsigned bytes_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned msgs_closed     = 0;
  int unsigned reg_writes      = 0;
  int unsigned enc_bytes       = 0;
  int unsigned dec_bytes       = 0;

  bit          src_idle       = 1'b1;
  bit          sink_idle      = 1'b1;
  int unsigned sink_hold_left = 0;
  int unsigned sink_gap_left  = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [CFG_DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void reset_shadow();
    sh_decrypt = 1'b0;
    sh_key_len = KEY_LEN_RESET;
    sh_key     = '0;
    msg_pos    = 0;
    fb_ptr     = 0;
    for (int i = 0; i < KEY_BYTES; i++) fb_line[i] = '0;
  endfunction

  // one byte through the cipher; advances position and feedback line
  function automatic out_beat_t cipher_step(input byte_t din, input logic lst);
    int unsigned lag;
    int unsigned tap;
    byte_t       addend;
    out_beat_t   res;
    lag = 32'(sh_key_len);
    if (lag < 1) lag = 1;
    if (lag > KEY_BYTES) lag = KEY_BYTES;
    if (msg_pos < lag) begin
      if (msg_pos < KEY_SLOTS) addend = sh_key[8*msg_pos +: 8];
      else addend = '0;
    end else begin
      tap    = (fb_ptr + KEY_BYTES - lag) % KEY_BYTES;
      addend = fb_line[tap];
    end
    res.last = lst;
    if (sh_decrypt) begin
      res.data        = din - addend;
      fb_line[fb_ptr] = din;
      dec_bytes++;
    end else begin
      res.data        = din + addend;
      fb_line[fb_ptr] = res.data;
      enc_bytes++;
    end
    fb_ptr = (fb_ptr + 1) % KEY_BYTES;
    if (msg_pos < KEY_BYTES) msg_pos++;
    if (lst) begin
      msg_pos = 0;
      fb_ptr  = 0;
    end
    return res;
  endfunction

  task automatic send_byte(input byte_t d, input logic lst);
    int unsigned gap;
    gap = src_idle ? idle_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.data_in <= d;
    in_ch.last_in <= lst;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    expected_out.push_back(cipher_step(d, lst));
    bytes_sent++;
  endtask

  // up to eight bytes, first byte in the top lane
  task automatic send_seq(input logic [63:0] seq, input int n, input bit close);
    for (int i = n - 1; i >= 0; i--) send_byte(seq[8*i +: 8], close && (i == 0));
  endtask

  // stop offering, let every outstanding result come back, then settle
  task automatic wait_for_results();
    int unsigned n;
    in_ch.valid <= 1'b0;
    n = 0;
    while (expected_out.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // caller makes sure the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_MODE_DECRYPT: sh_decrypt = val[0];
      CFG_KEY_LENGTH:   sh_key_len = val[KEY_LEN_W-1:0];
      CFG_KEY_LOW:      sh_key[63:0] = val;
      CFG_KEY_HIGH:     sh_key[127:64] = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    // reset key is all zeros, so bytes pass unchanged
    send_seq(64'h00FF_0180, 4, 1'b1);
    wait_for_results();
  endtask

  task automatic test_short_lag();
    logic [CFG_DATA_W-1:0] v;
    write_reg(CFG_KEY_LOW, {CFG_DATA_W{1'b1}});
    write_reg(CFG_KEY_HIGH, 64'h8000_0000_0000_0001);
    // a lag code of zero behaves as one: feedback from the second byte
    v = rand64();
    v[KEY_LEN_W-1:0] = '0;
    write_reg(CFG_KEY_LENGTH, v);
    send_seq(64'hFF_FF00, 3, 1'b1);
    wait_for_results();
    // lag code above the key size clamps to the full key
    v = rand64();
    v[KEY_LEN_W-1:0] = {KEY_LEN_W{1'b1}};
    write_reg(CFG_KEY_LENGTH, v);
    send_seq(64'h7F80, 2, 1'b1);
    wait_for_results();
  endtask

  task automatic test_decrypt();
    logic [CFG_DATA_W-1:0] v;
    v = rand64();
    v[0] = 1'b1;
    write_reg(CFG_MODE_DECRYPT, v);
    write_reg(CFG_KEY_LENGTH, 64'd2);
    write_reg(CFG_KEY_LOW, rand64());
    send_seq(64'h00FF_A55A, 4, 1'b1);
    wait_for_results();
  endtask

  task automatic test_mode_switch_mid_message();
    write_reg(CFG_MODE_DECRYPT, 64'd0);
    write_reg(CFG_KEY_LENGTH, 64'd3);
    send_seq(64'h1122_33, 3, 1'b0);
    wait_for_results();
    // message still open: feedback now takes the received byte
    write_reg(CFG_MODE_DECRYPT, 64'd1);
    send_seq(64'hFE00_01, 3, 1'b1);
    wait_for_results();
    write_reg(CFG_MODE_DECRYPT, 64'd0);
  endtask

  task automatic test_unknown_index();
    write_reg(CFG_FIRST_UNUSED, rand64());
    write_reg({CFG_IDX_W{1'b1}}, rand64());
    send_seq(64'h5AA5, 2, 1'b1);
    wait_for_results();
  endtask

  task automatic test_output_stall();
    // sink holds off while the source keeps offering: input must stall
    src_idle       = 1'b0;
    sink_idle      = 1'b0;
    sink_hold_left = 300;
    for (int i = 0; i < 24; i++) send_byte(byte_t'($urandom), i == 23);
    wait_for_results();
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    sink_hold_left = 120;
    for (int i = 0; i < 16; i++) send_byte(byte_t'($urandom), i == 15);
    wait_for_results();
  endtask

  task automatic reconfigure_random();
    logic [CFG_DATA_W-1:0] v;
    int unsigned           r;
    wait_for_results();
    if ($urandom_range(0, 1) == 1) begin
      v = rand64();
      v[0] = 1'($urandom_range(0, 1));
      write_reg(CFG_MODE_DECRYPT, v);
    end
    // lag only changes between messages
    if (msg_pos == 0 && $urandom_range(0, 2) != 0) begin
      v = rand64();
      r = $urandom_range(0, 5);
      case (r)
        0: v[KEY_LEN_W-1:0] = '0;
        1: v[KEY_LEN_W-1:0] = 5'd1;
        2: v[KEY_LEN_W-1:0] = KEY_LEN_W'(KEY_BYTES);
        3: v[KEY_LEN_W-1:0] = {KEY_LEN_W{1'b1}};
        default: v[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(0, 31));
      endcase
      write_reg(CFG_KEY_LENGTH, v);
    end
    for (int h = 0; h < 2; h++) begin
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 5);
        if (r == 0) v = '0;
        else if (r == 1) v = {CFG_DATA_W{1'b1}};
        else v = rand64();
        write_reg(h == 0 ? CFG_KEY_LOW : CFG_KEY_HIGH, v);
      end
    end
    if ($urandom_range(0, 7) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, {CFG_IDX_W{1'b1}})),
                rand64());
  endtask

  task automatic test_random_messages();
    int unsigned budget;
    int unsigned len;
    int unsigned r;
    bit          close;
    while (bytes_sent < RANDOM_TARGET) begin
      reconfigure_random();
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      budget    = $urandom_range(20, 60);
      while (budget != 0) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 20);
        else if (r < 95) len = $urandom_range(17, 40);
        else len = 1;
        if (len > budget) len = budget;
        budget -= len;
        // the phase's last message is sometimes left open
        close = (budget != 0) || ($urandom_range(0, 4) != 0);
        for (int i = 0; i < len; i++)
          send_byte(byte_t'($urandom), close && (i == len - 1));
      end
    end
    wait_for_results();
  endtask

  // result sink: random gaps, plus a counted hold-off on request
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_left != 0) begin
        out_ch.ready <= 1'b0;
        sink_hold_left--;
      end else if (sink_gap_left != 0) begin
        out_ch.ready <= 1'b0;
        sink_gap_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_idle && $urandom_range(0, 3) == 0) sink_gap_left = idle_gap();
      end
    end
  end

  initial begin : check_results
    out_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_out.size() == 0) begin
          $error("result beat with nothing outstanding: data_out %02h last_out %0b",
                 out_ch.data_out, out_ch.last_out);
          error_count++;
        end else begin
          want = expected_out.pop_front();
          if (out_ch.data_out !== want.data) begin
            $error("data_out mismatch: expected %02h, actual %02h",
                   want.data, out_ch.data_out);
            error_count++;
          end
          if (out_ch.last_out !== want.last) begin
            $error("last_out mismatch: expected %0b, actual %0b",
                   want.last, out_ch.last_out);
            error_count++;
          end
          results_checked++;
          if (want.last) msgs_closed++;
        end
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("watchdog expired, %0d results outstanding", expected_out.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : run_tests
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data_in = '0;
    in_ch.last_in = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.wdata  = '0;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_state();
    test_short_lag();
    test_decrypt();
    test_mode_switch_mid_message();
    test_unknown_index();
    test_output_stall();
    test_random_messages();

    wait_for_results();
    if (expected_out.size() != 0) begin
      $error("%0d expected results never arrived", expected_out.size());
      error_count += expected_out.size();
    end
    $display("Checked %0d result beats over %0d closed messages (%0d enc, %0d dec bytes)",
             results_checked, msgs_closed, enc_bytes, dec_bytes);
    $display("%0d register writes incl. clamped lag codes and unmapped indexes; %0d errors",
             reg_writes, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : tb_lagged_additive_byte_cipher

/* filelist.f */
hdl/lab_pkg.sv
hdl/lab_if.sv
hdl/lagged_additive_byte_cipher.sv
hdl/lab_checker.sv
sim/tb_lagged_additive_byte_cipher.sv
